### src/nnot_pkg.sv
// Shared types and constants for the nearest-neighbor object tracker.
package nnot_pkg;

  localparam int MaxObjects = 16;
  localparam int IdxW       = (MaxObjects > 1) ? $clog2(MaxObjects) : 1;
  localparam int CntW       = $clog2(MaxObjects + 1);
  localparam int LiveW      = $clog2(MaxObjects + 1);

  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic        valid;
    logic        found;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] id;
    logic [7:0]  missing;
  } slot_t;

  typedef enum logic [2:0] {
    KIND_MATCH   = 3'd0,
    KIND_NEW     = 3'd1,
    KIND_DROPPED = 3'd2,
    KIND_KEPT    = 3'd3,
    KIND_REMOVED = 3'd4,
    KIND_DONE    = 3'd5
  } kind_t;

  localparam logic CFG_MAX_DISTANCE = 1'b0;
  localparam logic CFG_MAX_MISSING  = 1'b1;

  // ring control from the sequencer to the cell chain
  typedef struct packed {
    logic  shift;
    logic  load;
    idx_t  load_idx;
    slot_t load_data;
    slot_t tail_data;
  } ring_ctl_t;

endpackage

### src/nearest_neighbour_object_tracker.sv
// Top level: greedy nearest-neighbor object tracker built as a ring of slot cells.
// Input channel (in_valid/in_ready): one request per keypoint (in_action = 0,
// position in 12.4 fixed point) or per end of frame (in_action = 1).
// Output channel (out_valid/out_ready): a keypoint gives one result; an end of
// frame gives one result per live object in slot order, then a frame-done
// result. out_last marks the final result of each request.
// The table is a ring of 16 cells that rotates one slot per cycle, while a scan
// or count runs or a report is not stalled, past a single head position where
// the sequencer looks at it. Keypoint: one full rotation computing squared
// distances through a registered multiplier stage, then a drain state and a
// decide state, which registers the result once the output register is free.
// End of frame: one rotation counting the survivors (for out_live_count), one
// rotation reporting and aging the objects, then the frame-done result. One
// request is worked on at a time; in_ready is high only while idle, and a
// request is taken even while the last result still waits in the output
// register. A stalled receiver holds the output register and the decide or done
// state; in a report it also freezes the ring until the result is taken.
// Reset (rst_n low, synchronous) clears all valid and found marks, the next
// object ID, the live count, and sets max_distance = 320, max_missing = 5.
// cfg_we writes register cfg_index (0 max_distance, 1 max_missing) at once.
module nearest_neighbour_object_tracker import nnot_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [15:0]      in_position_x,
  input  logic [15:0]      in_position_y,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_object_id,
  output logic [15:0]      out_object_x,
  output logic [15:0]      out_object_y,
  output logic [LiveW-1:0] out_live_count,
  output logic             out_last,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_wdata
);

  slot_t     cell_q [MaxObjects];
  ring_ctl_t ring;

  // cell 0 is the head; data moves toward it, the head wraps to the tail
  for (genvar i = 0; i < MaxObjects; i++) begin : g_cell
    slot_t shift_in;
    if (i == MaxObjects - 1) begin : g_tail
      assign shift_in = ring.tail_data;
    end else begin : g_mid
      assign shift_in = cell_q[i+1];
    end
    nnot_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (ring.shift),
      .load      (ring.load && (ring.load_idx == IdxW'(i))),
      .shift_in  (shift_in),
      .load_data (ring.load_data),
      .q         (cell_q[i])
    );
  end

  nnot_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_position_x  (in_position_x),
    .in_position_y  (in_position_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_object_id  (out_object_id),
    .out_object_x   (out_object_x),
    .out_object_y   (out_object_y),
    .out_live_count (out_live_count),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .head           (cell_q[0]),
    .ring           (ring)
  );

endmodule

### src/nnot_cell.sv
// One table cell of the ring: holds a slot, shifts toward the head or loads.
module nnot_cell import nnot_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift,
  input  logic  load,
  input  slot_t shift_in,
  input  slot_t load_data,
  output slot_t q
);

  slot_t slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
      slot_r.found <= 1'b0;
    end else if (load) begin
      slot_r <= load_data;
    end else if (shift) begin
      slot_r <= shift_in;
    end
  end

  assign q = slot_r;

endmodule

### src/nnot_ctrl.sv
// Sequencer: scans the ring head, picks matches, ages objects, drives results.
module nnot_ctrl import nnot_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [15:0]      in_position_x,
  input  logic [15:0]      in_position_y,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_object_id,
  output logic [15:0]      out_object_x,
  output logic [15:0]      out_object_y,
  output logic [LiveW-1:0] out_live_count,
  output logic             out_last,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_wdata,
  input  slot_t            head,
  output ring_ctl_t        ring
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_DRAIN  = 7'b0000100,
    ST_DECIDE = 7'b0001000,
    ST_COUNT  = 7'b0010000,
    ST_REPORT = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CntW-1:0]   cnt_r;
  logic [15:0]       px_r, py_r;
  logic [15:0]       md_r;
  logic [7:0]        mm_r;
  logic [31:0]       mdsq_r;
  // distance stage
  logic              p_go_r, p_elig_r;
  logic [31:0]       p_id_r;
  idx_t              p_idx_r;
  logic [31:0]       sqx_r, sqy_r;
  // best candidate / free slot
  logic              best_ok_r;
  logic [32:0]       best_d_r;
  logic [31:0]       best_id_r;
  idx_t              best_idx_r;
  logic              free_ok_r;
  idx_t              free_idx_r;
  logic [31:0]       next_id_r;
  logic [LiveW-1:0]  live_r, surv_r;
  // output register
  logic              out_valid_r;
  logic [2:0]        out_kind_r;
  logic [31:0]       out_id_r;
  logic [15:0]       out_x_r, out_y_r;
  logic [LiveW-1:0]  out_live_r;
  logic              out_last_r;

  logic              accept, can_emit, last_step;
  idx_t              head_idx;
  logic [15:0]       dx, dy;
  logic [32:0]       d_sum;
  logic              better, is_match;
  logic [7:0]        miss_inc;
  logic              removed, survive, rep_stall;
  slot_t             wb;
  logic              emit;
  kind_t             e_kind;
  logic [31:0]       e_id;
  logic [15:0]       e_x, e_y;
  logic [LiveW-1:0]  e_live;
  logic              e_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign can_emit  = !out_valid_r || out_ready;
  assign head_idx  = cnt_r[IdxW-1:0];
  assign last_step = (cnt_r == CntW'(MaxObjects - 1));

  assign dx = (px_r >= head.x) ? (px_r - head.x) : (head.x - px_r);
  assign dy = (py_r >= head.y) ? (py_r - head.y) : (head.y - py_r);
  assign d_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign better = !best_ok_r || (d_sum < best_d_r) ||
                  ((d_sum == best_d_r) && (p_id_r < best_id_r));
  assign is_match = best_ok_r && (best_d_r <= {1'b0, mdsq_r});

  // aging of the head slot at end of frame
  assign miss_inc = (head.missing != 8'hFF) ? (head.missing + 8'd1) : head.missing;
  assign removed  = head.valid && !head.found && (miss_inc >= mm_r);
  assign survive  = head.valid && !removed;
  assign rep_stall = head.valid && !can_emit;

  always_comb begin
    wb = head;
    wb.found = 1'b0;
    if (head.valid && !head.found) begin
      wb.missing = miss_inc;
    end
    if (removed) begin
      wb.valid = 1'b0;
    end
  end

  // ring control
  always_comb begin
    ring.shift     = (state_r == ST_SCAN) || (state_r == ST_COUNT) ||
                     ((state_r == ST_REPORT) && !rep_stall);
    ring.tail_data = (state_r == ST_REPORT) ? wb : head;
    ring.load      = 1'b0;
    ring.load_idx  = free_idx_r;
    ring.load_data.valid   = 1'b1;
    ring.load_data.found   = 1'b1;
    ring.load_data.x       = px_r;
    ring.load_data.y       = py_r;
    ring.load_data.id      = next_id_r;
    ring.load_data.missing = 8'd0;
    if ((state_r == ST_DECIDE) && can_emit) begin
      if (is_match) begin
        ring.load         = 1'b1;
        ring.load_idx     = best_idx_r;
        ring.load_data.id = best_id_r;
      end else if (free_ok_r) begin
        ring.load = 1'b1;
      end
    end
  end

  // result selection and next state
  always_comb begin
    state_nxt = state_r;
    emit   = 1'b0;
    e_kind = KIND_DONE;
    e_id   = 32'd0;
    e_x    = 16'd0;
    e_y    = 16'd0;
    e_live = live_r;
    e_last = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_action ? ST_COUNT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        e_x    = px_r;
        e_y    = py_r;
        e_last = 1'b1;
        if (is_match) begin
          e_kind = KIND_MATCH;
          e_id   = best_id_r;
        end else if (free_ok_r) begin
          e_kind = KIND_NEW;
          e_id   = next_id_r;
          e_live = live_r + LiveW'(1);
        end else begin
          e_kind = KIND_DROPPED;
        end
        if (can_emit) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_COUNT: begin
        if (last_step) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        e_kind = removed ? KIND_REMOVED : KIND_KEPT;
        e_id   = head.id;
        e_x    = head.x;
        e_y    = head.y;
        emit   = head.valid && can_emit;
        if (!rep_stall && last_step) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        e_kind = KIND_DONE;
        e_last = 1'b1;
        if (can_emit) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      md_r        <= 16'd320;
      mm_r        <= 8'd5;
      next_id_r   <= 32'd0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      p_go_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_DISTANCE: md_r <= cfg_wdata;
          CFG_MAX_MISSING:  mm_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      p_go_r <= (state_r == ST_SCAN);
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == ST_DECIDE) && can_emit && !is_match && free_ok_r) begin
        next_id_r <= next_id_r + 32'd1;
        live_r    <= live_r + LiveW'(1);
      end
      if ((state_r == ST_COUNT) && last_step) begin
        live_r <= surv_r + LiveW'(survive);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mdsq_r <= md_r * md_r;
    if (accept) begin
      px_r      <= in_position_x;
      py_r      <= in_position_y;
      cnt_r     <= '0;
      best_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
      surv_r    <= '0;
    end
    if (state_r == ST_SCAN) begin
      cnt_r    <= last_step ? '0 : cnt_r + CntW'(1);
      p_elig_r <= head.valid && !head.found;
      p_id_r   <= head.id;
      p_idx_r  <= head_idx;
      sqx_r    <= dx * dx;
      sqy_r    <= dy * dy;
      if (!head.valid && !free_ok_r) begin
        free_ok_r  <= 1'b1;
        free_idx_r <= head_idx;
      end
    end
    if (p_go_r && p_elig_r && better) begin
      best_ok_r  <= 1'b1;
      best_d_r   <= d_sum;
      best_id_r  <= p_id_r;
      best_idx_r <= p_idx_r;
    end
    if (state_r == ST_COUNT) begin
      cnt_r  <= last_step ? '0 : cnt_r + CntW'(1);
      surv_r <= surv_r + LiveW'(survive);
    end
    if ((state_r == ST_REPORT) && !rep_stall) begin
      cnt_r <= cnt_r + CntW'(1);
    end
    if (emit) begin
      out_kind_r <= e_kind;
      out_id_r   <= e_id;
      out_x_r    <= e_x;
      out_y_r    <= e_y;
      out_live_r <= e_live;
      out_last_r <= e_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_object_id  = out_id_r;
  assign out_object_x   = out_x_r;
  assign out_object_y   = out_y_r;
  assign out_live_count = out_live_r;
  assign out_last       = out_last_r;

endmodule
